// ===== hw/rtl/assert_macros.svh =====
// Assertion helper macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mrpt_pkg.sv =====
// ----------------------------------------------------------------------------
// mrpt_pkg
// Shared types and constants for the 64-bit Miller-Rabin prime test unit.
// ----------------------------------------------------------------------------
package mrpt_pkg;

    localparam int unsigned W = 64;
    localparam int unsigned BW = 7;   // bit counter width (0..64)
    localparam int unsigned NBASE = 12;
    localparam int unsigned KW = 4;

    // Small primes, also used as the witness bases
    function automatic logic [5:0] prime_at(input logic [KW-1:0] k);
        logic [5:0] p;
        case (k)
            4'd0: p = 6'd2;
            4'd1: p = 6'd3;
            4'd2: p = 6'd5;
            4'd3: p = 6'd7;
            4'd4: p = 6'd11;
            4'd5: p = 6'd13;
            4'd6: p = 6'd17;
            4'd7: p = 6'd19;
            4'd8: p = 6'd23;
            4'd9: p = 6'd29;
            4'd10: p = 6'd31;
            default: p = 6'd37;
        endcase
        return p;
    endfunction

    // Modular multiplier command
    typedef struct packed {
        logic          start;
        logic [W-1:0]  x;
        logic [W-1:0]  y;
        logic [W-1:0]  m;
    } mm_cmd_t;

    typedef struct packed {
        logic          done;
        logic [W-1:0]  r;
    } mm_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRIAL,
        ST_SPLIT,
        ST_BASE,
        ST_POW_MUL,
        ST_POW_SQR,
        ST_CHECK,
        ST_SQ_LOOP,
        ST_DONE
    } mr_state_t;

endpackage

// ===== hw/rtl/miller_rabin_prime_test_64_unit.sv =====
// A strong prime needs at most about 125 multiplies for each of the 12 bases,
// after the trial divisions.
// Throughput: one candidate at a time; the next beat is taken only after the
// result beat is accepted. The bit-serial multiplier sets the rate.
// Reset: synchronous active-low aresetn returns the controller to idle and
// drops m_valid; no clearing pass.
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_64_unit
// Deterministic 64-bit primality test: trial division then strong tests.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_64_unit
    import mrpt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [W-1:0] s_candidate,
    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_is_prime
);
    `include "assert_macros.svh"

    mr_state_t     state_reg, state_next;
    logic [W-1:0]  n_reg, n_next;
    logic [W-1:0]  d_reg, d_next;
    logic [W-1:0]  e_reg, e_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  x_reg, x_next;
    logic [BW-1:0] s_reg, s_next;
    logic [BW-1:0] i_reg, i_next;
    logic [KW-1:0] k_reg, k_next;
    logic          go_reg, go_next;
    logic          res_reg, res_next;
    logic          mval_reg, mval_next;

    mm_cmd_t       mm_cmd;
    mm_rsp_t       mm_rsp;
    logic          rd_start, rd_done;
    logic [5:0]    rd_rem;
    logic [5:0]    prime_k;
    logic [W-1:0]  nm1;

    assign prime_k = prime_at(k_reg);
    assign nm1     = n_reg - 1'b1;

    mrpt_mod_reduce u_red (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rd_start),
        .value     (n_reg),
        .divisor   (prime_k),
        .done      (rd_done),
        .remainder (rd_rem)
    );

    mrpt_mod_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mm_cmd),
        .rsp     (mm_rsp)
    );

    // Controller state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            go_reg    <= 1'b0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            go_reg    <= go_next;
            mval_reg  <= mval_next;
        end
        n_reg   <= n_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
        b_reg   <= b_next;
        x_reg   <= x_next;
        s_reg   <= s_next;
        i_reg   <= i_next;
        k_reg   <= k_next;
        res_reg <= res_next;
    end

    // Next state and datapath control; go_reg issues a unit start
    always_comb begin
        state_next = state_reg;
        n_next = n_reg; d_next = d_reg; e_next = e_reg; b_next = b_reg;
        x_next = x_reg; s_next = s_reg; i_next = i_reg; k_next = k_reg;
        res_next = res_reg; mval_next = mval_reg; go_next = 1'b0;
        rd_start = 1'b0;
        mm_cmd   = '{start: 1'b0, x: x_reg, y: x_reg, m: n_reg};
        s_ready  = (state_reg == ST_IDLE) && !mval_reg;
        if (mval_reg && m_ready) mval_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    n_next = s_candidate;
                    k_next = '0;
                    if (s_candidate < W'(2)) begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        go_next    = 1'b1;
                        state_next = ST_TRIAL;
                    end
                end
            end
            ST_TRIAL: begin
                rd_start = go_reg;
                if (rd_done) begin
                    if (rd_rem == '0) begin
                        res_next   = (n_reg == W'(prime_k));
                        state_next = ST_DONE;
                    end else if (k_reg == KW'(NBASE - 1)) begin
                        d_next     = nm1;
                        s_next     = '0;
                        state_next = ST_SPLIT;
                    end else begin
                        k_next  = k_reg + 1'b1;
                        go_next = 1'b1;
                    end
                end
            end
            ST_SPLIT: begin
                if (d_reg[0]) begin
                    k_next     = '0;
                    state_next = ST_BASE;
                end else begin
                    d_next = {1'b0, d_reg[W-1:1]};
                    s_next = s_reg + 1'b1;
                end
            end
            ST_BASE: begin
                // n > 37 so each base is already reduced
                x_next = W'(1);
                b_next = W'(prime_k);
                e_next = d_reg;
                if (d_reg[0]) begin
                    go_next    = 1'b1;
                    state_next = ST_POW_MUL;
                end
            end
            ST_POW_MUL: begin
                mm_cmd = '{start: go_reg, x: b_reg, y: x_reg, m: n_reg};
                if (mm_rsp.done) begin
                    x_next     = mm_rsp.r;
                    e_next     = {1'b0, e_reg[W-1:1]};
                    go_next    = 1'b1;
                    state_next = ST_POW_SQR;
                end
            end
            ST_POW_SQR: begin
                if (e_reg == '0) begin
                    i_next     = BW'(1);
                    state_next = ST_CHECK;
                end else begin
                    mm_cmd = '{start: go_reg, x: b_reg, y: b_reg, m: n_reg};
                    if (mm_rsp.done) begin
                        b_next  = mm_rsp.r;
                        go_next = 1'b1;
                        if (e_reg[0]) state_next = ST_POW_MUL;
                        else e_next = {1'b0, e_reg[W-1:1]};
                    end
                end
            end
            ST_CHECK: begin
                if (x_reg == W'(1) || x_reg == nm1) begin
                    if (k_reg == KW'(NBASE - 1)) begin
                        res_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_BASE;
                    end
                end else if (i_reg >= s_reg) begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    go_next    = 1'b1;
                    state_next = ST_SQ_LOOP;
                end
            end
            ST_SQ_LOOP: begin
                mm_cmd = '{start: go_reg, x: x_reg, y: x_reg, m: n_reg};
                if (mm_rsp.done) begin
                    x_next = mm_rsp.r;
                    i_next = i_reg + 1'b1;
                    // only x == n-1 ends the loop as a pass; x == 1 keeps squaring and fails at the end
                    if (mm_rsp.r == nm1) begin
                        if (k_reg == KW'(NBASE - 1)) begin
                            res_next   = 1'b1;
                            state_next = ST_DONE;
                        end else begin
                            k_next     = k_reg + 1'b1;
                            state_next = ST_BASE;
                        end
                    end else if (i_reg + 1'b1 >= s_reg) begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        go_next = 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (!mval_reg) begin
                    mval_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid    = mval_reg;
    assign m_is_prime = res_reg;

    `ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_is_prime), "result dropped")
    `ASSERT_IMPL(a_busy_noaccept, aclk, aresetn, state_reg != ST_IDLE, !s_ready, "accept while busy")
    `ASSERT_IMPL(a_k_range, aclk, aresetn, state_reg != ST_IDLE, k_reg < KW'(NBASE), "base index out of range")
endmodule

// ===== hw/rtl/mrpt_mod_reduce.sv =====
// ----------------------------------------------------------------------------
// mrpt_mod_reduce
// Bit-serial remainder of a 64-bit value by a small divisor input.
// ----------------------------------------------------------------------------
module mrpt_mod_reduce
    import mrpt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] value,
    input  logic [5:0]   divisor,
    output logic         done,
    output logic [5:0]   remainder
);
    `include "assert_macros.svh"

    logic [W-1:0] val_reg, val_next;
    logic [5:0]   rem_reg, rem_next;
    logic [BW-1:0] cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic [6:0]   shifted;

    // One dividend bit per cycle, restoring remainder
    always_comb begin
        shifted   = {rem_reg, val_reg[W-1]};
        val_next  = val_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            val_next  = value;
            rem_next  = '0;
            cnt_next  = BW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            val_next = {val_reg[W-2:0], 1'b0};
            rem_next = (shifted >= {1'b0, divisor}) ?
                       6'(shifted - {1'b0, divisor}) : shifted[5:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == BW'(1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        val_reg <= val_next;
        rem_reg <= rem_next;
    end

    assign done      = busy_reg && (cnt_reg == BW'(1));
    assign remainder = rem_next;

    `ASSERT_IMPL(a_rem_lt_div, aclk, aresetn, busy_reg, rem_reg < divisor, "remainder >= divisor")
    `ASSERT_NEXT(a_done_idle, aclk, aresetn, done && !start, !busy_reg, "busy after done")
    `ASSERT_IMPL(a_cnt_busy, aclk, aresetn, busy_reg, cnt_reg != '0, "busy with zero count")
endmodule

// ===== hw/rtl/mrpt_mod_mul.sv =====
// ----------------------------------------------------------------------------
// mrpt_mod_mul
// Bit-serial modular multiplier: double-and-add over the multiplier bits.
// ----------------------------------------------------------------------------
module mrpt_mod_mul
    import mrpt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  mm_cmd_t cmd,
    output mm_rsp_t rsp
);
    `include "assert_macros.svh"

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;
    logic [W-1:0]  m_reg, m_next;
    logic [BW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [W:0]    dbl, dbl_red, sum;
    logic [W-1:0]  acc_a;

    // x < m is guaranteed by the caller; each step: acc=2acc (+x) mod m
    always_comb begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        acc_a   = dbl_red[W-1:0];
        sum     = {1'b0, acc_a} + {1'b0, x_reg};
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        m_next    = m_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (cmd.start) begin
            acc_next  = '0;
            x_next    = cmd.x;
            y_next    = cmd.y;
            m_next    = cmd.m;
            cnt_next  = BW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (y_reg[W-1])
                acc_next = (sum >= {1'b0, m_reg}) ? W'(sum - {1'b0, m_reg}) : sum[W-1:0];
            else
                acc_next = acc_a;
            y_next   = {y_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == BW'(1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        m_reg   <= m_next;
    end

    assign rsp.done = busy_reg && (cnt_reg == BW'(1));
    assign rsp.r    = acc_next;

    `ASSERT_IMPL(a_acc_lt_m, aclk, aresetn, busy_reg, acc_reg < m_reg, "accumulator not reduced")
    `ASSERT_NEXT(a_done_idle, aclk, aresetn, rsp.done && !cmd.start, !busy_reg, "busy after done")
    `ASSERT_IMPL(a_no_restart, aclk, aresetn, busy_reg && !rsp.done, !cmd.start, "start while busy")
endmodule

// ===== tb/tb_miller_rabin_prime_test_64_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_miller_rabin_prime_test_64_unit
// Self-checking bench for the 64-bit primality unit. Candidates go in through
// the s_ channel. A local primality predictor built on wide modular arithmetic
// sets the expected verdict for each accepted beat. Each m_ beat is checked
// in order against those verdicts; in later phases one or both sides idle at random.
// ----------------------------------------------------------------------------
module tb_miller_rabin_prime_test_64_unit;
    import mrpt_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_valid;
    logic         s_ready;
    logic [W-1:0] s_candidate;
    logic         m_valid;
    logic         m_ready;
    logic         m_is_prime;

    // verdicts waiting for their result beat, and the candidates behind them
    bit           expected_verdicts[$];
    logic [W-1:0] pending_candidates[$];
    int           mismatch_count;
    int           send_idle_pct;
    int           recv_stall_pct;

    miller_rabin_prime_test_64_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_candidate (s_candidate),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_is_prime  (m_is_prime)
    );

    always #4 aclk = ~aclk;

    // (a * b) mod m over the full 128-bit product
    function automatic logic [W-1:0] mul_mod(logic [W-1:0] a, logic [W-1:0] b,
                                             logic [W-1:0] m);
        logic [2*W-1:0] prod;
        prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
        return W'(prod % {{W{1'b0}}, m});
    endfunction

    function automatic logic [W-1:0] pow_mod(logic [W-1:0] b, logic [W-1:0] e,
                                             logic [W-1:0] m);
        logic [W-1:0] acc;
        logic [W-1:0] sq;
        acc = 1;
        sq = b % m;
        while (e != 0) begin
            if (e[0]) acc = mul_mod(acc, sq, m);
            sq = mul_mod(sq, sq, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    // trial division by small primes, then strong tests for bases 2..37
    function automatic bit primality_verdict(logic [W-1:0] n);
        int unsigned  small_primes[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
        logic [W-1:0] nm1;
        logic [W-1:0] d;
        logic [W-1:0] x;
        int           twos;
        bit           witness;
        if (n < 2) return 0;
        foreach (small_primes[k])
            if (n % small_primes[k] == 0) return n == small_primes[k];
        nm1 = n - 1;
        d = nm1;
        twos = 0;
        while (!d[0]) begin
            d = d >> 1;
            twos++;
        end
        foreach (small_primes[k]) begin
            x = pow_mod(small_primes[k], d, n);
            if (x == 1 || x == nm1) continue;
            witness = 1;
            for (int i = 1; i < twos; i++) begin
                x = mul_mod(x, x, n);
                if (x == nm1) begin
                    witness = 0;
                    break;
                end
            end
            if (witness) return 0;
        end
        return 1;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] ERROR: %s", $time, what);
        mismatch_count++;
    endtask

    // receiver stalls, driven on the falling edge
    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat is_prime=%0b", m_is_prime));
            end else begin
                if (m_is_prime !== expected_verdicts[0])
                    report_mismatch($sformatf("candidate %0d: is_prime=%0b, want %0b",
                        pending_candidates[0], m_is_prime, expected_verdicts[0]));
                void'(expected_verdicts.pop_front());
                void'(pending_candidates.pop_front());
            end
        end
    end

    // one candidate beat; returns at the falling edge after acceptance
    task automatic send_candidate(logic [W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 0;
            @(negedge aclk);
        end
        s_valid = 1;
        s_candidate = value;
        do @(posedge aclk); while (!s_ready);
        expected_verdicts.insert(expected_verdicts.size(), primality_verdict(value));
        pending_candidates.insert(pending_candidates.size(), value);
        @(negedge aclk);
        s_valid = 0;
    endtask

    task automatic wait_drained();
        while (expected_verdicts.size() != 0) @(negedge aclk);
    endtask

    // edges of the range, small primes, squares and strong pseudoprimes
    task automatic test_directed();
        logic [W-1:0] vals[$] = '{
            64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd37, 64'd41, 64'd1681,
            64'd561, 64'd2047, 64'd3215031751, 64'd3825123056546413051,
            64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
            64'h1FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFC5,
            64'd4294967291, 64'd65521, 64'd1369, 64'd1763};
        foreach (vals[i]) send_candidate(vals[i]);
    endtask

    // cheap 16-bit candidates, products of two 32-bit values, and full-width values that exercise every bit
    task automatic test_random(int count);
        logic [W-1:0] v;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(4))
                0, 1: v = $urandom_range(65535);
                2: v = {32'd0, $urandom} * {32'd0, $urandom};
                default: v = {$urandom, $urandom};
            endcase
            send_candidate(v);
            if (i == count / 2) wait_drained();
        end
    endtask

    initial begin
        aclk = 0;
        aresetn = 0;
        s_valid = 0;
        s_candidate = '0;
        m_ready = 0;
        mismatch_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        test_directed();
        test_random(20);
        send_idle_pct = 71;
        test_random(20);
        send_idle_pct = 0;
        recv_stall_pct = 71;
        test_random(20);
        send_idle_pct = 13;
        recv_stall_pct = 13;
        test_random(20);

        wait_drained();
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0 && expected_verdicts.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial begin
        #(64'd100_000_000 * 8);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== miller_rabin_prime_test_64_unit.f =====
+incdir+hw/rtl
hw/rtl/mrpt_pkg.sv
hw/rtl/mrpt_mod_reduce.sv
hw/rtl/mrpt_mod_mul.sv
hw/rtl/miller_rabin_prime_test_64_unit.sv
tb/tb_miller_rabin_prime_test_64_unit.sv
